[rtl/core/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

[rtl/core/mhpq_pkg.sv]
// Shared types, constants and codes of the max-heap priority queue.
package mhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = IDX_W + 2;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] value;
  } mhpq_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic                     found;
    logic [1:0]               status;
    logic [CNT_W-1:0]         entry_count;
  } mhpq_rsp_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_SET_FULL,
    CMD_SET_EMPTY,
    CMD_INS_INIT,
    CMD_UP_READ,
    CMD_UP_MOVE,
    CMD_PUT_CUR,
    CMD_RD_ROOT,
    CMD_RD_LAST,
    CMD_TAKE_LAST,
    CMD_DN_READ_LEFT,
    CMD_DN_LEFT,
    CMD_DN_RIGHT,
    CMD_DN_MOVE,
    CMD_SCAN
  } mhpq_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       full;
    logic       empty;
    logic       pos_zero;
    logic       cur_gt_rd;
    logic       left_ok;
    logic       right_ok;
    logic       big_mv;
    logic       scan_done;
  } mhpq_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_CHK,
    S_UP_CMP,
    S_DEL_LAST,
    S_DEL_TAKE,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_DN_MV,
    S_SCAN,
    S_RESP
  } mhpq_state_t;

endpackage

[rtl/core/mhpq_datapath.sv]
// Heap store, moving-entry registers, index arithmetic and result registers.
module mhpq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  mhpq_pkg::mhpq_cmd_t  cmd,
  input  mhpq_pkg::mhpq_req_t  req_in,
  output mhpq_pkg::mhpq_stat_t stat,
  output mhpq_pkg::mhpq_rsp_t  rsp
);
  import mhpq_pkg::*;

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] cur;
  logic signed [DATA_W-1:0] big_val;
  logic signed [DATA_W-1:0] removed;
  mhpq_req_t                req_r;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         scan;
  logic [IDX_W-1:0]         pos;
  logic [IDX_W-1:0]         big_idx;
  logic                     big_mv;
  logic                     found;
  logic                     rd_vld;
  logic [1:0]               status;

  logic [IDX_W-1:0]         parent_idx;
  logic [CMP_W-1:0]         left_idx;
  logic [CMP_W-1:0]         right_idx;
  logic [CMP_W-1:0]         cnt_ext;
  logic [CNT_W-1:0]         cnt_m1;
  logic                     scan_more;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  always_comb begin
    parent_idx = (pos - IDX_W'(1)) >> 1;
    left_idx   = {1'b0, pos, 1'b1};
    right_idx  = left_idx + CMP_W'(1);
    cnt_ext    = CMP_W'(count);
    cnt_m1     = count - CNT_W'(1);
    scan_more  = (scan < count);
  end

  // single read port, single write port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = cur;
    case (cmd)
      CMD_UP_READ: begin
        rd_en   = 1'b1;
        rd_addr = parent_idx;
      end
      CMD_RD_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      CMD_RD_LAST: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m1[IDX_W-1:0];
      end
      CMD_DN_READ_LEFT: begin
        rd_en   = 1'b1;
        rd_addr = left_idx[IDX_W-1:0];
      end
      CMD_DN_LEFT: begin
        // right child fetched while left is compared; unused when out of range
        rd_en   = 1'b1;
        rd_addr = right_idx[IDX_W-1:0];
      end
      CMD_SCAN: begin
        rd_en   = scan_more;
        rd_addr = scan[IDX_W-1:0];
      end
      CMD_UP_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      CMD_PUT_CUR: begin
        wr_en   = 1'b1;
      end
      CMD_DN_MOVE: begin
        wr_en   = 1'b1;
        wr_data = big_val;
      end
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd)
        CMD_INS_INIT: count <= count + CNT_W'(1);
        CMD_RD_LAST:  count <= cnt_m1;
        default:      count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        req_r   <= req_in;
        removed <= '0;
        found   <= 1'b0;
        status  <= ST_OK;
        scan    <= '0;
        rd_vld  <= 1'b0;
      end
      CMD_SET_FULL:  status <= ST_FULL;
      CMD_SET_EMPTY: status <= ST_EMPTY;
      CMD_INS_INIT: begin
        pos <= count[IDX_W-1:0];
        cur <= req_r.value;
      end
      CMD_UP_MOVE: pos <= parent_idx;
      CMD_RD_LAST: removed <= rd_data;
      CMD_TAKE_LAST: begin
        cur <= rd_data;
        pos <= '0;
      end
      CMD_DN_READ_LEFT: begin
        big_val <= cur;
        big_idx <= pos;
        big_mv  <= 1'b0;
      end
      CMD_DN_LEFT: begin
        if (rd_data > big_val) begin
          big_val <= rd_data;
          big_idx <= left_idx[IDX_W-1:0];
          big_mv  <= 1'b1;
        end
      end
      CMD_DN_RIGHT: begin
        if (rd_data > big_val) begin
          big_val <= rd_data;
          big_idx <= right_idx[IDX_W-1:0];
          big_mv  <= 1'b1;
        end
      end
      CMD_DN_MOVE: pos <= big_idx;
      CMD_SCAN: begin
        if (rd_vld && (rd_data == req_r.value)) begin
          found <= 1'b1;
        end
        rd_vld <= scan_more;
        if (scan_more) begin
          scan <= scan + CNT_W'(1);
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

  always_comb begin
    stat.req_type  = req_r.req_type;
    stat.full      = (count == CNT_W'(CAPACITY));
    stat.empty     = (count == '0);
    stat.pos_zero  = (pos == '0);
    stat.cur_gt_rd = (cur > rd_data);
    stat.left_ok   = (left_idx < cnt_ext);
    stat.right_ok  = (right_idx < cnt_ext);
    stat.big_mv    = big_mv;
    stat.scan_done = found || (!scan_more && !rd_vld);

    rsp.removed_value = removed;
    rsp.found         = found;
    rsp.status        = status;
    rsp.entry_count   = count;
  end

endmodule

[rtl/core/mhpq_ctrl.sv]
// Sequencer that steps the datapath through insert, delete and search.
module mhpq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  mhpq_pkg::mhpq_stat_t stat,
  output mhpq_pkg::mhpq_cmd_t  cmd,
  output logic                 busy,
  output logic                 done
);
  import mhpq_pkg::*;

  mhpq_state_t state;
  mhpq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.req_type)
          REQ_INSERT: state_next = stat.full ? S_RESP : S_UP_CHK;
          REQ_DELETE: state_next = stat.empty ? S_RESP : S_DEL_LAST;
          REQ_SEARCH: state_next = S_SCAN;
          default:    state_next = S_RESP;
        endcase
      end
      S_UP_CHK:   state_next = stat.pos_zero ? S_RESP : S_UP_CMP;
      S_UP_CMP:   state_next = stat.cur_gt_rd ? S_UP_CHK : S_RESP;
      S_DEL_LAST: state_next = S_DEL_TAKE;
      S_DEL_TAKE: state_next = S_DN_CHK;
      S_DN_CHK:   state_next = stat.left_ok ? S_DN_L : S_RESP;
      S_DN_L:     state_next = stat.right_ok ? S_DN_R : S_DN_MV;
      S_DN_R:     state_next = S_DN_MV;
      S_DN_MV:    state_next = stat.big_mv ? S_DN_CHK : S_RESP;
      S_SCAN:     state_next = stat.scan_done ? S_RESP : S_SCAN;
      S_RESP:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = CMD_NOP;
    busy = (state != S_IDLE);
    done = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) cmd = CMD_LOAD;
      end
      S_DECODE: begin
        case (stat.req_type)
          REQ_INSERT: cmd = stat.full ? CMD_SET_FULL : CMD_INS_INIT;
          REQ_DELETE: cmd = stat.empty ? CMD_SET_EMPTY : CMD_RD_ROOT;
          default:    cmd = CMD_NOP;
        endcase
      end
      S_UP_CHK:   cmd = stat.pos_zero ? CMD_PUT_CUR : CMD_UP_READ;
      S_UP_CMP:   cmd = stat.cur_gt_rd ? CMD_UP_MOVE : CMD_PUT_CUR;
      S_DEL_LAST: cmd = CMD_RD_LAST;
      S_DEL_TAKE: cmd = CMD_TAKE_LAST;
      S_DN_CHK:   cmd = stat.left_ok ? CMD_DN_READ_LEFT : CMD_PUT_CUR;
      S_DN_L:     cmd = CMD_DN_LEFT;
      S_DN_R:     cmd = CMD_DN_RIGHT;
      S_DN_MV:    cmd = stat.big_mv ? CMD_DN_MOVE : CMD_PUT_CUR;
      S_SCAN:     cmd = stat.scan_done ? CMD_NOP : CMD_SCAN;
      S_RESP:     done = 1'b1;
      default:    cmd = CMD_NOP;
    endcase
  end

endmodule

[rtl/core/max_heap_priority_queue_top.sv]
// Top level of the max-heap priority queue: controller plus datapath.
//
// A request (insert, delete-max or search) is taken when start is high and
// busy is low; busy then stays high until the response. The response is shown
// for exactly one cycle with done high and cannot be stalled; the next request
// may be taken the cycle after. The heap lives in a single-port-read,
// single-port-write memory of 64 entries, one access of each kind per cycle,
// and that port sets the latency. Delete-max does two child reads and one write
// per level moved; search reads one entry per cycle, ending early on a hit.
// Refused requests and the unused request code go from decode straight to the
// response. The store needs no clearing after reset; only entries below the
// entry count are ever used.
module max_heap_priority_queue_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mhpq_pkg::mhpq_req_t req,
  output logic                done,
  output mhpq_pkg::mhpq_rsp_t rsp
);
  import mhpq_pkg::*;

  mhpq_cmd_t  cmd;
  mhpq_stat_t stat;

  mhpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mhpq_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req_in (req),
    .stat   (stat),
    .rsp    (rsp)
  );

endmodule

[rtl/core/mhpq_checker.sv]
// Port-level checks for the max-heap priority queue, bound to the top level.
`include "assert_macros.svh"

module mhpq_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input mhpq_pkg::mhpq_req_t req,
  input logic                done,
  input mhpq_pkg::mhpq_rsp_t rsp
);
  import mhpq_pkg::*;

  // a taken transaction raises busy, and a response comes only while busy
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted transaction did not raise busy")
  `ASSERT_IMPL(a_done_busy, done, busy, "response outside a transaction")
  `ASSERT_CLK(a_done_single, done |=> !done, "response shown for more than one cycle")
  `ASSERT_IMPL(a_count_cap, done, rsp.entry_count <= CNT_W'(CAPACITY), "entry count beyond capacity")
  `ASSERT_IMPL(a_refused_clean, done && (rsp.status != ST_OK),
               (rsp.removed_value == '0) && !rsp.found, "refused request carried data")

endmodule

bind max_heap_priority_queue_top mhpq_checker u_mhpq_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);

[tb/testbench.sv]
// Self-checking testbench of the max-heap priority queue top level.
`timescale 1ns / 100ps

module testbench;
  import mhpq_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int TOTAL_ITEMS = 1900;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    mhpq_req_t   req;
    int unsigned idle_pct;
  } queued_req_t;

  logic      clk;
  logic      rst;
  logic      start = 1'b0;
  logic      busy;
  mhpq_req_t req = '0;
  logic      done;
  mhpq_rsp_t rsp;

  queued_req_t pending_reqs[$];
  mhpq_rsp_t   expected_rsps[$];

  // Shadow copy of the heap
  logic signed [DATA_W-1:0] heap_vals[CAPACITY];
  int                       heap_size = 0;

  int error_count = 0;
  int gen_count = 0;
  int unsigned phase_idle_pct = 0;

  max_heap_priority_queue_top dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #16_000_000;
    $display("tb: failure");
    $finish;
  end

  // Applies one request to the shadow heap and returns the response it yields.
  function automatic mhpq_rsp_t heap_apply(mhpq_req_t r);
    mhpq_rsp_t                outcome;
    int                       pos;
    int                       parent;
    int                       left;
    int                       right;
    int                       big;
    logic signed [DATA_W-1:0] tmp;
    outcome = '0;
    outcome.status = ST_OK;
    case (r.req_type)
      REQ_INSERT: begin
        if (heap_size >= CAPACITY) begin
          outcome.status = ST_FULL;
        end else begin
          heap_vals[heap_size] = r.value;
          pos = heap_size;
          heap_size++;
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!(heap_vals[pos] > heap_vals[parent])) break;
            tmp = heap_vals[pos];
            heap_vals[pos] = heap_vals[parent];
            heap_vals[parent] = tmp;
            pos = parent;
          end
        end
      end
      REQ_DELETE: begin
        if (heap_size == 0) begin
          outcome.status = ST_EMPTY;
        end else begin
          outcome.removed_value = heap_vals[0];
          heap_size--;
          heap_vals[0] = heap_vals[heap_size];
          pos = 0;
          while (1) begin
            left = 2 * pos + 1;
            right = left + 1;
            big = pos;
            // strict compares: left child wins a tie
            if (left < heap_size && heap_vals[left] > heap_vals[big]) big = left;
            if (right < heap_size && heap_vals[right] > heap_vals[big]) big = right;
            if (big == pos) break;
            tmp = heap_vals[pos];
            heap_vals[pos] = heap_vals[big];
            heap_vals[big] = tmp;
            pos = big;
          end
        end
      end
      REQ_SEARCH: begin
        for (int i = 0; i < heap_size; i++) begin
          if (heap_vals[i] == r.value) begin
            outcome.found = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    outcome.entry_count = CNT_W'(heap_size);
    return outcome;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3, 4, 5, 6: v = $signed($urandom_range(0, 15)) - 8;  // small pool: ties and hits
      7: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = '0;
          default: v = -1;
        endcase
      end
      8: v = 32'sh7FFF_FFFF - $signed($urandom_range(0, 3));
      default: v = 32'sh8000_0000 + $signed($urandom_range(0, 3));
    endcase
    return v;
  endfunction

  task automatic queue_req(logic [1:0] kind, logic signed [DATA_W-1:0] v);
    queued_req_t item;
    item.req.req_type = kind;
    item.req.value = v;
    item.idle_pct = phase_idle_pct;
    pending_reqs.push_back(item);
    if (kind != REQ_UNUSED) gen_count++;
  endtask

  task automatic build_stimulus();
    int          run_len;
    int unsigned pick;
    // directed: empty cases, extremes, equal keys, unused code, drain past empty
    queue_req(REQ_DELETE, 32'sd0);
    queue_req(REQ_SEARCH, 32'sd0);
    queue_req(REQ_UNUSED, 32'sh1234_5678);
    queue_req(REQ_INSERT, 32'sh7FFF_FFFF);
    queue_req(REQ_INSERT, 32'sh8000_0000);
    queue_req(REQ_INSERT, 32'sd0);
    queue_req(REQ_INSERT, -32'sd1);
    queue_req(REQ_INSERT, 32'sd5);
    queue_req(REQ_INSERT, 32'sd5);
    queue_req(REQ_INSERT, 32'sd5);
    queue_req(REQ_SEARCH, 32'sd5);
    queue_req(REQ_SEARCH, 32'sh8000_0000);
    queue_req(REQ_SEARCH, 32'sd6);
    queue_req(REQ_UNUSED, -32'sd1);
    repeat (8) queue_req(REQ_DELETE, $urandom);
    // random part in four idle phases: none, 70%, none, 35%
    while (gen_count < TOTAL_ITEMS) begin
      case ((gen_count * 4) / TOTAL_ITEMS)
        0: phase_idle_pct = 0;
        1: phase_idle_pct = 70;
        2: phase_idle_pct = 0;
        default: phase_idle_pct = 35;
      endcase
      case ($urandom_range(0, 9))
        0: begin
          // fill past capacity so full refusals occur
          run_len = $urandom_range(64, 72);
          repeat (run_len) queue_req(REQ_INSERT, pick_value());
        end
        1: begin
          run_len = $urandom_range(64, 72);
          repeat (run_len) queue_req(REQ_DELETE, $urandom);
        end
        default: begin
          repeat (20) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) queue_req(REQ_INSERT, pick_value());
            else if (pick < 70) queue_req(REQ_DELETE, $urandom);
            else if (pick < 96) queue_req(REQ_SEARCH, pick_value());
            else queue_req(REQ_UNUSED, $urandom);
          end
        end
      endcase
    end
  endtask

  // Driver: start holds until the transaction is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      req <= '0;
    end else begin
      if (start && !busy) expected_rsps.push_back(heap_apply(req));
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 &&
            $urandom_range(0, 99) >= pending_reqs[0].idle_pct) begin
          req <= pending_reqs[0].req;
          void'(pending_reqs.pop_front());
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    mhpq_rsp_t want;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected response: removed=%0d found=%0d status=%0d count=%0d",
                   rsp.removed_value, rsp.found, rsp.status, rsp.entry_count);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.removed_value !== want.removed_value || rsp.found !== want.found ||
            rsp.status !== want.status || rsp.entry_count !== want.entry_count) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: exp removed=%0d found=%0d status=%0d count=%0d",
                     want.removed_value, want.found, want.status, want.entry_count,
                     " / got removed=%0d found=%0d status=%0d count=%0d",
                     rsp.removed_value, rsp.found, rsp.status, rsp.entry_count);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    build_stimulus();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || start) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[max_heap_priority_queue_top.f]
+incdir+rtl/core
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_datapath.sv
rtl/core/mhpq_ctrl.sv
rtl/core/max_heap_priority_queue_top.sv
rtl/core/mhpq_checker.sv
tb/testbench.sv
